// ===== rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, root kind codes and payload types of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    localparam int CW       = 16;
    localparam int OUT_FRAC = 16;
    localparam int OW       = 32;
    localparam int DW       = 2 * CW + 1;
    localparam int SW       = (DW + 2 * OUT_FRAC + 1) / 2;
    localparam int RW       = 2 * SW;
    localparam int NW       = CW + OUT_FRAC + 3;
    localparam int UW       = CW + 18;
    localparam int VW       = CW + 1;

    typedef enum logic [1:0] {
        KIND_TWO     = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_DEGEN   = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [CW-1:0] coef_a;
        logic signed [CW-1:0] coef_b;
        logic signed [CW-1:0] coef_c;
    } t_coef;

    typedef struct packed {
        t_kind                root_kind;
        logic signed [OW-1:0] first_value;
        logic signed [OW-1:0] second_value;
        logic                 saturated;
    } t_result;

    typedef struct packed {
        t_kind                kind;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic [SW-1:0]        s;
    } t_mid;

endpackage

`default_nettype wire

// ===== rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver
// Throughput is one beat per cycle while no end stalls on a full queue, set
// by the bit-per-stage square root and division pipelines and the queues
// that part the front and back ends.
// Reset is synchronous and active low; it empties both queues and clears
// all stage valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire qrs_pkg::t_coef   i_coef,
    output logic                  empty,
    input  wire logic             pop,
    output qrs_pkg::t_result      o_res
);

    localparam int MW = $bits(qrs_pkg::t_mid);
    localparam int RSW = $bits(qrs_pkg::t_result);

    logic             f_push;
    qrs_pkg::t_mid    f_mid;
    logic             m_full;
    logic             m_empty;
    logic [MW-1:0]    m_data;
    logic             b_pop;
    logic             b_push;
    qrs_pkg::t_result b_res;
    logic             o_full_q;
    logic [RSW-1:0]   o_data;

    qrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (push),
        .i_coef      (i_coef),
        .o_busy      (full),
        .i_down_full (m_full),
        .o_push      (f_push),
        .o_mid       (f_mid)
    );

    qrs_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_mid),
        .o_full  (m_full),
        .i_pop   (b_pop),
        .o_empty (m_empty),
        .o_data  (m_data)
    );

    qrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!m_empty),
        .i_mid       (qrs_pkg::t_mid'(m_data)),
        .o_pop       (b_pop),
        .i_down_full (o_full_q),
        .o_push      (b_push),
        .o_res       (b_res)
    );

    qrs_fifo #(.WIDTH(RSW), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_res),
        .o_full  (o_full_q),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_data)
    );

    assign o_res = qrs_pkg::t_result'(o_data);

endmodule

`default_nettype wire

// ===== rtl/qrs_fifo.sv =====
// ----------------------------------------------------------------------------
// Solver queue
// Small first-in first-out queue of register entries.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNW-1:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qrs_front.sv =====
// ----------------------------------------------------------------------------
// Solver front end
// Forms the discriminant, classifies it and takes its square root, one
// result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire qrs_pkg::t_coef i_coef,
    output logic               o_busy,
    input  wire logic          i_down_full,
    output logic               o_push,
    output qrs_pkg::t_mid      o_mid
);

    localparam int CW = qrs_pkg::CW;
    localparam int DW = qrs_pkg::DW;
    localparam int SW = qrs_pkg::SW;
    localparam int RW = qrs_pkg::RW;

    logic en;

    logic                 r1_vld;
    logic signed [CW-1:0] r1_a;
    logic signed [CW-1:0] r1_b;
    logic [2*CW-1:0]      r1_prod;
    logic [2*CW-1:0]      r1_bsq;
    logic                 r1_diff;
    logic                 r1_azero;

    logic [CW-1:0]        ma;
    logic [CW-1:0]        mb;
    logic [CW-1:0]        mc;

    logic                 r_vld  [SW+1];
    logic [SW+1:0]        r_rem  [SW+1];
    logic [SW-1:0]        r_root [SW+1];
    logic [RW-1:0]        r_rad  [SW+1];
    qrs_pkg::t_kind       r_kind [SW+1];
    logic signed [CW-1:0] r_a    [SW+1];
    logic signed [CW-1:0] r_b    [SW+1];

    logic [DW-1:0]        p;
    logic [DW-1:0]        q;
    logic [DW-1:0]        d;
    logic                 dneg;
    qrs_pkg::t_kind       kind;

    assign en     = !(r_vld[SW] && i_down_full);
    assign o_busy = !en;
    assign o_push = r_vld[SW] && en;
    assign o_mid  = '{kind: r_kind[SW], a: r_a[SW], b: r_b[SW], s: r_root[SW]};

    always_comb begin
        ma = i_coef.coef_a[CW-1] ? CW'(-i_coef.coef_a) : i_coef.coef_a;
        mb = i_coef.coef_b[CW-1] ? CW'(-i_coef.coef_b) : i_coef.coef_b;
        mc = i_coef.coef_c[CW-1] ? CW'(-i_coef.coef_c) : i_coef.coef_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a     <= i_coef.coef_a;
            r1_b     <= i_coef.coef_b;
            r1_prod  <= (2*CW)'(ma) * (2*CW)'(mc);
            r1_bsq   <= (2*CW)'(mb) * (2*CW)'(mb);
            r1_diff  <= i_coef.coef_a[CW-1] != i_coef.coef_c[CW-1];
            r1_azero <= (i_coef.coef_a == '0);
        end
    end

    always_comb begin
        p    = DW'(r1_bsq);
        q    = DW'({r1_prod, 2'b00});
        dneg = 1'b0;
        if (r1_prod != '0 && r1_diff) begin
            d = p + q;
        end else if (p >= q) begin
            d = p - q;
        end else begin
            d    = q - p;
            dneg = 1'b1;
        end
        if (r1_azero) begin
            kind = qrs_pkg::KIND_DEGEN;
        end else if (d == '0) begin
            kind = qrs_pkg::KIND_DOUBLE;
        end else if (dneg) begin
            kind = qrs_pkg::KIND_COMPLEX;
        end else begin
            kind = qrs_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= RW'({d, {(2*qrs_pkg::OUT_FRAC){1'b0}}});
            r_kind[0] <= kind;
            r_a[0]    <= r1_a;
            r_b[0]    <= r1_b;
        end
    end

    for (genvar k = 1; k <= SW; k++) begin : g_sqrt
        logic [SW+1:0] rem_sh;
        logic [SW+1:0] trial;
        logic          take;

        always_comb begin
            rem_sh = {r_rem[k-1][SW-1:0], r_rad[k-1][RW-1 -: 2]};
            trial  = {r_root[k-1], 2'b01};
            take   = rem_sh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k]  <= take ? rem_sh - trial : rem_sh;
                r_root[k] <= {r_root[k-1][SW-2:0], take};
                r_rad[k]  <= {r_rad[k-1][RW-3:0], 2'b00};
                r_kind[k] <= r_kind[k-1];
                r_a[k]    <= r_a[k-1];
                r_b[k]    <= r_b[k-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qrs_back.sv =====
// ----------------------------------------------------------------------------
// Solver back end
// Builds both numerators and divides them by twice a in two pipelined
// lanes with rounding and clipping to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire qrs_pkg::t_mid  i_mid,
    output logic                o_pop,
    input  wire logic           i_down_full,
    output logic                o_push,
    output qrs_pkg::t_result    o_res
);

    localparam int CW = qrs_pkg::CW;
    localparam int SW = qrs_pkg::SW;
    localparam int NW = qrs_pkg::NW;
    localparam int UW = qrs_pkg::UW;
    localparam int VW = qrs_pkg::VW;
    localparam int OW = qrs_pkg::OW;
    localparam logic [UW-1:0] NEG_LIM = UW'(64'h8000_0000);
    localparam logic [UW-1:0] POS_LIM = UW'(64'h7FFF_FFFF);

    logic en;

    logic                 r_vld  [UW+1];
    qrs_pkg::t_kind       r_kind [UW+1];
    logic [VW-1:0]        r_ud   [UW+1];
    logic [UW-1:0]        r_dv   [UW+1][2];
    logic [VW-1:0]        r_rem  [UW+1][2];
    logic [UW-1:0]        r_quo  [UW+1][2];
    logic                 r_neg  [UW+1][2];

    logic                 r_ovld;
    qrs_pkg::t_result     r_out;

    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] sx;
    logic signed [NW-1:0] num [2];
    logic signed [NW-1:0] nmag;
    logic [VW-1:0]        ud;
    logic                 dsign [2];
    logic [UW-1:0]        dv0 [2];
    logic                 neg0 [2];

    logic [OW-1:0]        val [2];
    logic                 sat [2];

    assign en     = !(r_ovld && i_down_full);
    assign o_pop  = en && i_valid;
    assign o_push = r_ovld && en;
    assign o_res  = r_out;

    always_comb begin
        nb = -(NW'(i_mid.b) <<< qrs_pkg::OUT_FRAC);
        sx = $signed({{(NW-SW){1'b0}}, i_mid.s});
        ud = i_mid.a[CW-1] ? VW'(-(VW'(i_mid.a) <<< 1)) : VW'(VW'(i_mid.a) <<< 1);
        if (i_mid.kind == qrs_pkg::KIND_COMPLEX) begin
            num[0] = nb;
            num[1] = sx;
            dsign[0] = i_mid.a[CW-1];
            dsign[1] = 1'b0;
        end else begin
            num[0] = nb - sx;
            num[1] = nb + sx;
            dsign[0] = i_mid.a[CW-1];
            dsign[1] = i_mid.a[CW-1];
        end
        for (int l = 0; l < 2; l++) begin
            nmag    = num[l][NW-1] ? -num[l] : num[l];
            dv0[l]  = UW'($unsigned(nmag)) + UW'(ud >> 1);
            neg0[l] = num[l][NW-1] != dsign[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind[0] <= i_mid.kind;
            r_ud[0]   <= ud;
            for (int l = 0; l < 2; l++) begin
                r_dv[0][l]  <= dv0[l];
                r_rem[0][l] <= '0;
                r_quo[0][l] <= '0;
                r_neg[0][l] <= neg0[l];
            end
        end
    end

    for (genvar k = 1; k <= UW; k++) begin : g_div
        logic [VW:0] rem_sh [2];
        logic        take   [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                rem_sh[l] = {r_rem[k-1][l], r_dv[k-1][l][UW-1]};
                take[l]   = rem_sh[l] >= {1'b0, r_ud[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_kind[k] <= r_kind[k-1];
                r_ud[k]   <= r_ud[k-1];
                for (int l = 0; l < 2; l++) begin
                    r_rem[k][l] <= take[l] ? VW'(rem_sh[l] - {1'b0, r_ud[k-1]})
                                           : VW'(rem_sh[l]);
                    r_dv[k][l]  <= {r_dv[k-1][l][UW-2:0], 1'b0};
                    r_quo[k][l] <= {r_quo[k-1][l][UW-2:0], take[l]};
                    r_neg[k][l] <= r_neg[k-1][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_neg[UW][l]) begin
                sat[l] = r_quo[UW][l] > NEG_LIM;
                val[l] = sat[l] ? OW'(NEG_LIM) : OW'(-r_quo[UW][l]);
            end else begin
                sat[l] = r_quo[UW][l] > POS_LIM;
                val[l] = sat[l] ? OW'(POS_LIM) : OW'(r_quo[UW][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vld[UW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.root_kind <= r_kind[UW];
            if (r_kind[UW] == qrs_pkg::KIND_DEGEN) begin
                r_out.first_value  <= '0;
                r_out.second_value <= '0;
                r_out.saturated    <= 1'b0;
            end else begin
                r_out.first_value  <= $signed(val[0]);
                r_out.second_value <= $signed(val[1]);
                r_out.saturated    <= sat[0] || sat[1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Port-level properties of the solver, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             empty,
    input wire logic             pop,
    input wire qrs_pkg::t_result o_res
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("Result queue not empty after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("Waiting result changed or vanished.");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.root_kind == qrs_pkg::KIND_DEGEN) |->
        (o_res.first_value == '0 && o_res.second_value == '0 && !o_res.saturated))
        else $error("Degenerate result carries values.");

    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.root_kind == qrs_pkg::KIND_DOUBLE) |->
        (o_res.first_value == o_res.second_value))
        else $error("Double root halves differ.");

    a_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.root_kind == qrs_pkg::KIND_COMPLEX) |->
        !o_res.second_value[31])
        else $error("Imaginary magnitude is negative.");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Feeds directed and random coefficient sets through the queue interface,
// predicts each root pair in the testbench and checks every result beat
// in order, with idle and stall phases on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        qrs_pkg::t_coef coef;
        int             send_pct;
        int             recv_pct;
        bit             drain;
    } t_pending;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             pop = 1'b0;
    qrs_pkg::t_coef   i_coef = '0;
    logic             full;
    logic             empty;
    qrs_pkg::t_result o_res;

    t_pending         pending_q[$];
    qrs_pkg::t_result roots_q[$];
    int               recv_pct = 0;
    int               errors = 0;
    int               quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    quadratic_root_solver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_coef  (i_coef),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    function automatic logic [127:0] isqrt(logic [127:0] x);
        logic [127:0] res;
        logic [127:0] bitv;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] round_clip(longint n, longint d, inout bit sat);
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un + ud / 2) / ud;
        if ((n < 0) != (d < 0)) begin
            if (q > 64'h8000_0000) begin
                sat = 1'b1;
                q = 64'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            q = 64'h7FFF_FFFF;
        end
        return 32'(q);
    endfunction

    function automatic qrs_pkg::t_result solve_roots(qrs_pkg::t_coef cf);
        qrs_pkg::t_result r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint s;
        longint nb;
        bit sat;
        a = cf.coef_a;
        b = cf.coef_b;
        c = cf.coef_c;
        sat = 1'b0;
        r = '0;
        if (a == 0) begin
            r.root_kind = qrs_pkg::KIND_DEGEN;
            return r;
        end
        disc = b * b - 4 * a * c;
        s = longint'(isqrt(128'(disc < 0 ? -disc : disc) << 32));
        nb = -b * 65536;
        if (disc == 0) begin
            r.root_kind = qrs_pkg::KIND_DOUBLE;
            r.first_value = round_clip(nb, 2 * a, sat);
            r.second_value = r.first_value;
        end else if (disc > 0) begin
            r.root_kind = qrs_pkg::KIND_TWO;
            r.first_value = round_clip(nb - s, 2 * a, sat);
            r.second_value = round_clip(nb + s, 2 * a, sat);
        end else begin
            r.root_kind = qrs_pkg::KIND_COMPLEX;
            r.first_value = round_clip(nb, 2 * a, sat);
            r.second_value = round_clip(s, (a < 0) ? -2 * a : 2 * a, sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n) begin
            if (push && !full) begin
                roots_q.push_back(solve_roots(pending_q[0].coef));
                recv_pct = pending_q[0].recv_pct;
                pending_q.pop_front();
            end
            if (pending_q.size() != 0) begin
                p = pending_q[0];
                if ((p.drain && roots_q.size() != 0) ||
                    $urandom_range(99) < p.send_pct) begin
                    push <= 1'b0;
                end else begin
                    push <= 1'b1;
                    i_coef <= p.coef;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        qrs_pkg::t_result e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (roots_q.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, o_res);
                    errors++;
                end else begin
                    e = roots_q.pop_front();
                    if (o_res.root_kind !== e.root_kind ||
                        o_res.first_value !== e.first_value ||
                        o_res.second_value !== e.second_value ||
                        o_res.saturated !== e.saturated) begin
                        $display("%0t: expected %0d %h %h %b, got %0d %h %h %b",
                                 $time, e.root_kind, e.first_value, e.second_value,
                                 e.saturated, o_res.root_kind, o_res.first_value,
                                 o_res.second_value, o_res.saturated);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_set(int a, int b, int c, int sp, int rp, bit dr);
        t_pending p;
        p.coef.coef_a = 16'(a);
        p.coef.coef_b = 16'(b);
        p.coef.coef_c = 16'(c);
        p.send_pct = sp;
        p.recv_pct = rp;
        p.drain = dr;
        pending_q.push_back(p);
    endtask

    initial begin
        int sp;
        int rp;
        int a;
        int r;
        add_set(0, 123, -45, 0, 0, 0);
        add_set(0, -32768, 32767, 0, 0, 0);
        add_set(1, 2, 1, 0, 0, 0);
        add_set(-3, 12, -12, 0, 0, 0);
        add_set(1, 0, 1, 0, 0, 0);
        add_set(-1, 0, -1, 0, 0, 0);
        add_set(1, 3, -4, 0, 0, 0);
        add_set(1, -32768, -32768, 0, 0, 0);
        add_set(1, 32767, -32768, 0, 0, 0);
        add_set(-1, -32768, 32767, 0, 0, 0);
        add_set(32767, 32767, 32767, 0, 0, 0);
        add_set(-32768, -32768, -32768, 0, 0, 0);
        add_set(-32768, 32767, 32767, 0, 0, 0);
        add_set(32767, -32768, -32768, 0, 0, 0);
        add_set(1, 1, 32767, 0, 0, 0);
        add_set(-1, 0, 0, 0, 0, 0);
        add_set(256, -512, 256, 0, 0, 0);
        add_set(-1, 1, -32768, 0, 0, 0);
        add_set(32767, 0, -1, 0, 0, 0);
        add_set(-32768, 0, 1, 0, 0, 0);
        for (int i = 0; i < 700; i++) begin
            case (i / 175)
                0: begin sp = 0;  rp = 0;  end
                1: begin sp = 51; rp = 0;  end
                2: begin sp = 0;  rp = 51; end
                default: begin sp = 28; rp = 28; end
            endcase
            if (i % 175 > 120) begin
                sp = 0;
                rp = 0;
            end
            case ($urandom_range(9))
                0: add_set(0, $urandom, $urandom, sp, rp, i == 350);
                1: begin
                    a = $urandom_range(1, 40) * (($urandom_range(1)) ? 1 : -1);
                    r = $urandom_range(0, 28) - 14;
                    add_set(a, -2 * a * r, a * r * r, sp, rp, i == 350);
                end
                2, 3: add_set($urandom_range(0, 6) - 3, $urandom, $urandom, sp, rp, i == 350);
                default: add_set($urandom, $urandom, $urandom, sp, rp, i == 350);
            endcase
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || roots_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
